// File: rtl/core/cte_pkg.sv
// shared types, constants and helpers for the certificate time to epoch converter
`timescale 1ns / 1ps
package cte_pkg;

  localparam int LONG_FORM_LEN = 17;
  localparam int SHORT_MIN_LEN = 14;
  localparam int COUNT_W       = 5;
  localparam int COUNT_MAX     = 31;
  localparam int DIGIT_FIRST   = 2;
  localparam int DIGIT_COUNT   = 14;
  localparam int STORE_DEPTH   = DIGIT_FIRST + DIGIT_COUNT;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);
  localparam int PAIR_COUNT    = DIGIT_COUNT / 2;
  localparam int YEAR_W        = 14;
  localparam int DAYS_W        = 24;
  localparam int EPOCH_W       = 39;
  localparam int PIVOT_W       = 7;
  localparam int PIVOT_RESET   = 50;
  // march-based year shifted by 400 so it never goes negative
  localparam int DAY_OFFSET    = 719468 + 146097;
  // reciprocal of 25 scaled by 2^17, exact for dividends below 43000
  localparam int RECIP25       = 5243;
  localparam int RECIP_SHIFT   = 17;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NON_DIGIT = 2'd1,
    ST_BAD_MONTH = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_t;

  typedef struct packed {
    logic [DIGIT_COUNT-1:0][7:0] chars;
    logic [COUNT_W-1:0]          count;
  } snap_t;

  typedef struct packed {
    status_t             status;
    logic [YEAR_W-1:0]   year;
    logic [3:0]          mon;
    logic [6:0]          day;
    logic [6:0]          hr;
    logic [6:0]          mi;
    logic [6:0]          sc;
  } fields_t;

  typedef struct packed {
    status_t      status;
    logic [21:0]  y365;
    logic [11:0]  q4;
    logic [6:0]   q100;
    logic [4:0]   q400;
    logic [8:0]   doy;
    logic [6:0]   day;
    logic [6:0]   hr;
    logic [6:0]   mi;
    logic [6:0]   sc;
  } terms_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DAYS_W-1:0]  days;
    logic [6:0]                hr;
    logic [6:0]                mi;
    logic [6:0]                sc;
  } days_t;

  function automatic logic [6:0] pair_value(input logic [3:0] a, input logic [3:0] b);
    pair_value = 7'(a) * 7'd10 + 7'(b);
  endfunction

  // days from 1 march to the first of the month, month counted from march
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    case (mp)
      4'd0:    month_start = 9'd0;
      4'd1:    month_start = 9'd31;
      4'd2:    month_start = 9'd61;
      4'd3:    month_start = 9'd92;
      4'd4:    month_start = 9'd122;
      4'd5:    month_start = 9'd153;
      4'd6:    month_start = 9'd184;
      4'd7:    month_start = 9'd214;
      4'd8:    month_start = 9'd245;
      4'd9:    month_start = 9'd275;
      4'd10:   month_start = 9'd306;
      4'd11:   month_start = 9'd337;
      default: month_start = 9'd0;
    endcase
  endfunction

endpackage

// File: rtl/core/cert_time_to_epoch.sv
// Certificate validity time string to signed seconds since 1970 UTC.
// The slave stream carries one byte of the string per transaction, tag and
// length bytes first, with tlast on the final byte. Each string gives exactly
// one master transaction: epoch seconds (two's complement) and a status code
// (0 ok, 1 non-digit, 2 month out of range, 3 too short); seconds are zero
// on any error. A string of 17 bytes is read as a four-digit year, any other
// length as a two-digit year whose century follows year_pivot.
// Every stage takes a new transaction each cycle, so s_tready stays high
// while the pipeline has room and one byte per cycle is sustained.
// The result passes through five register stages (capture, field decode, two
// day-count stages, seconds and result register), the capture register loading
// at the same edge that takes the last byte.
// When m_tready is low the result register holds its data and the earlier
// stages only move forward into empty stages; bytes keep flowing as long as the
// capture register is free.
// Reset clears the byte count, all valid flags and sets year_pivot to 50.
// year_pivot is written over the register port at byte address 0.
`timescale 1ns / 1ps
module cert_time_to_epoch (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [38:0] epoch_seconds, [40:39] status, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cte_pkg::*;

  logic [PIVOT_W-1:0]        year_pivot;
  logic                      snap_valid;
  logic                      snap_ready;
  snap_t                     snap;
  logic                      fields_valid;
  logic                      fields_ready;
  fields_t                   fields;
  logic                      days_valid;
  logic                      days_ready;
  days_t                     days;
  logic signed [EPOCH_W-1:0] epoch_seconds;
  logic [1:0]                status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-PIVOT_W){1'b0}}, year_pivot} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_pivot <= PIVOT_W'(PIVOT_RESET);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      year_pivot <= pwdata[PIVOT_W-1:0];
    end
  end

  cte_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .char_in   (s_tdata),
    .last_char (s_tlast),
    .out_valid (snap_valid),
    .out_ready (snap_ready),
    .snap      (snap)
  );

  cte_field_decode u_field_decode (
    .clk        (clk),
    .rst        (rst),
    .year_pivot (year_pivot),
    .in_valid   (snap_valid),
    .in_ready   (snap_ready),
    .snap       (snap),
    .out_valid  (fields_valid),
    .out_ready  (fields_ready),
    .fields     (fields)
  );

  cte_day_count u_day_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fields_valid),
    .in_ready  (fields_ready),
    .fields    (fields),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .days      (days)
  );

  cte_epoch_out u_epoch_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (days_valid),
    .in_ready      (days_ready),
    .days          (days),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .epoch_seconds (epoch_seconds),
    .status        (status)
  );

  assign m_tdata = {7'd0, status, epoch_seconds};

endmodule

// File: rtl/core/cte_capture.sv
// character counter, character store and snapshot register for the end of a string
`timescale 1ns / 1ps
module cte_capture (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    char_in,
  input  logic          last_char,
  output logic          out_valid,
  input  logic          out_ready,
  output cte_pkg::snap_t snap
);
  import cte_pkg::*;

  logic [7:0]         char_store [STORE_DEPTH];
  logic [COUNT_W-1:0] char_count;
  logic [COUNT_W-1:0] count_inc;
  logic               snap_valid;
  logic               take;
  snap_t              snap_next;

  assign in_ready  = !snap_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = snap_valid;
  assign count_inc = (char_count == COUNT_W'(COUNT_MAX)) ? char_count
                                                         : char_count + 1'b1;

  // the last character is merged in, it is not in the store yet
  always_comb begin
    snap_next.count = count_inc;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      snap_next.chars[i] = (char_count == COUNT_W'(i + DIGIT_FIRST)) ? char_in
                                                                    : char_store[i + DIGIT_FIRST];
    end
  end

  always_ff @(posedge clk) begin
    if (take && char_count < COUNT_W'(STORE_DEPTH)) begin
      char_store[char_count[STORE_AW-1:0]] <= char_in;
    end
    if (take && last_char) begin
      snap <= snap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (take) begin
        char_count <= last_char ? '0 : count_inc;
      end
      if (take && last_char) begin
        snap_valid <= 1'b1;
      end else if (out_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/cte_field_decode.sv
// digit check, field extraction, century choice and status priority
`timescale 1ns / 1ps
module cte_field_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [cte_pkg::PIVOT_W-1:0] year_pivot,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cte_pkg::snap_t           snap,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cte_pkg::fields_t         fields
);
  import cte_pkg::*;

  logic [DIGIT_COUNT-1:0] is_digit;
  logic [6:0]             pairs [PAIR_COUNT];
  logic                   long_form;
  logic                   too_short;
  logic                   digits_ok;
  logic [6:0]             lo;
  logic [6:0]             mon_pair;
  fields_t                fields_next;
  logic                   fields_valid;

  assign in_ready  = !fields_valid || out_ready;
  assign out_valid = fields_valid;

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      is_digit[i] = (snap.chars[i] >= 8'h30) && (snap.chars[i] <= 8'h39);
    end
    for (int j = 0; j < PAIR_COUNT; j++) begin
      pairs[j] = pair_value(snap.chars[2*j][3:0], snap.chars[2*j+1][3:0]);
    end
  end

  always_comb begin
    long_form = (snap.count == COUNT_W'(LONG_FORM_LEN));
    too_short = !long_form && (snap.count < COUNT_W'(SHORT_MIN_LEN));
    digits_ok = long_form ? (&is_digit) : (&is_digit[DIGIT_COUNT-3:0]);
    lo        = long_form ? pairs[1] : pairs[0];
    // full two-digit month, checked before it is cut to four bits
    mon_pair  = long_form ? pairs[2] : pairs[1];
    if (long_form) begin
      fields_next.year = YEAR_W'(pairs[0]) * YEAR_W'(100) + YEAR_W'(lo);
      fields_next.mon  = pairs[2][3:0];
      fields_next.day  = pairs[3];
      fields_next.hr   = pairs[4];
      fields_next.mi   = pairs[5];
      fields_next.sc   = pairs[6];
    end else begin
      fields_next.year = (lo >= year_pivot) ? YEAR_W'(lo) + YEAR_W'(1900)
                                            : YEAR_W'(lo) + YEAR_W'(2000);
      fields_next.mon  = pairs[1][3:0];
      fields_next.day  = pairs[2];
      fields_next.hr   = pairs[3];
      fields_next.mi   = pairs[4];
      fields_next.sc   = pairs[5];
    end
    // too short beats non-digit, non-digit beats a bad month
    if (too_short) begin
      fields_next.status = ST_TOO_SHORT;
    end else if (!digits_ok) begin
      fields_next.status = ST_NON_DIGIT;
    end else if (mon_pair == 7'd0 || mon_pair > 7'd12) begin
      fields_next.status = ST_BAD_MONTH;
    end else begin
      fields_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fields <= fields_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fields_valid <= 1'b0;
    end else if (in_ready) begin
      fields_valid <= in_valid;
    end
  end

endmodule

// File: rtl/core/cte_day_count.sv
// days since 1970 from year, month and day, in two register stages
`timescale 1ns / 1ps
module cte_day_count (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cte_pkg::fields_t fields,
  output logic             out_valid,
  input  logic             out_ready,
  output cte_pkg::days_t   days
);
  import cte_pkg::*;

  logic [YEAR_W-1:0] y_shift;
  logic [3:0]        mp;
  logic [24:0]       prod100;
  logic [24:0]       prod400;
  terms_t            terms;
  terms_t            terms_next;
  logic              terms_valid;
  logic              terms_ready;
  days_t             days_next;
  logic              days_valid;

  assign in_ready    = !terms_valid || terms_ready;
  assign terms_ready = !days_valid || out_ready;
  assign out_valid   = days_valid;

  // january and february belong to the previous march-based year
  always_comb begin
    y_shift = (fields.mon <= 4'd2) ? fields.year + YEAR_W'(399)
                                   : fields.year + YEAR_W'(400);
    mp      = (fields.mon > 4'd2) ? fields.mon - 4'd3 : fields.mon + 4'd9;
    prod100 = 25'(y_shift[YEAR_W-1:2]) * 25'(RECIP25);
    prod400 = 25'(y_shift[YEAR_W-1:4]) * 25'(RECIP25);
    terms_next.status = fields.status;
    terms_next.y365   = 22'(y_shift) * 22'(365);
    terms_next.q4     = y_shift[YEAR_W-1:2];
    terms_next.q100   = prod100[RECIP_SHIFT+6:RECIP_SHIFT];
    terms_next.q400   = prod400[RECIP_SHIFT+4:RECIP_SHIFT];
    terms_next.doy    = month_start(mp);
    terms_next.day    = fields.day;
    terms_next.hr     = fields.hr;
    terms_next.mi     = fields.mi;
    terms_next.sc     = fields.sc;
  end

  always_comb begin
    days_next.status = terms.status;
    days_next.days   = DAYS_W'(terms.y365) + DAYS_W'(terms.q4) + DAYS_W'(terms.q400)
                     + DAYS_W'(terms.doy) + DAYS_W'(terms.day) - DAYS_W'(terms.q100)
                     - DAYS_W'(DAY_OFFSET + 1);
    days_next.hr     = terms.hr;
    days_next.mi     = terms.mi;
    days_next.sc     = terms.sc;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      terms <= terms_next;
    end
    if (terms_valid && terms_ready) begin
      days <= days_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
      days_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        terms_valid <= in_valid;
      end
      if (terms_ready) begin
        days_valid <= terms_valid;
      end
    end
  end

endmodule

// File: rtl/core/cte_epoch_out.sv
// seconds from days and time of day, result register
`timescale 1ns / 1ps
module cte_epoch_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cte_pkg::days_t                days,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cte_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic [1:0]                    status
);
  import cte_pkg::*;

  logic signed [EPOCH_W-1:0] secs_next;
  logic                      res_valid;

  assign in_ready  = !res_valid || out_ready;
  assign out_valid = res_valid;

  always_comb begin
    secs_next = EPOCH_W'(days.days) * EPOCH_W'(86400)
              + EPOCH_W'(days.hr) * EPOCH_W'(3600)
              + EPOCH_W'(days.mi) * EPOCH_W'(60)
              + EPOCH_W'(days.sc);
    if (days.status != ST_OK) begin
      secs_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      epoch_seconds <= secs_next;
      status        <= days.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_ready) begin
      res_valid <= in_valid;
    end
  end

endmodule
